// ===== rtl/dbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared types and constants for the detection box post-processing block.
// ----------------------------------------------------------------------------
package dbp_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int CLS_W       = 7;   // class index field width
  localparam int CNT_W       = 8;   // scores seen in one query, up to MAX_CLASSES
  localparam int VAL_W       = 16;  // Q0.16 scores and coordinates, Q12.4 pixels
  localparam int NET_W       = 13;
  localparam int TCNT_W      = 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    FUNC_SCORE = 2'd0,
    FUNC_BOX   = 2'd1,
    FUNC_THR   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_NET_WIDTH  = 2'd0,
    REG_NET_HEIGHT = 2'd1,
    REG_THR_COUNT  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // One box that has passed its class and threshold checks
  typedef struct packed {
    logic [VAL_W-1:0] center_x;
    logic [VAL_W-1:0] center_y;
    logic [VAL_W-1:0] size_x;
    logic [VAL_W-1:0] size_y;
    logic [VAL_W-1:0] score;
    logic [CLS_W-1:0] class_id;
  } job_t;

  typedef struct packed {
    logic room2;
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/dbp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_in_if
// Input request channel: valid/ready plus the item fields.
// ----------------------------------------------------------------------------
interface dbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] score;
  logic [6:0]  class_index;
  logic [15:0] threshold_value;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] size_x;
  logic [15:0] size_y;

  modport source (
    output valid, func, score, class_index, threshold_value,
           center_x, center_y, size_x, size_y,
    input  ready
  );
  modport sink (
    input  valid, func, score, class_index, threshold_value,
           center_x, center_y, size_x, size_y,
    output ready
  );
endinterface

// ===== rtl/dbp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_out_if
// Result request channel: valid/ready plus the detection fields.
// ----------------------------------------------------------------------------
interface dbp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [15:0] confidence;
  logic [6:0]  class_id;

  modport source (
    output valid, left, top, box_width, box_height, confidence, class_id,
    input  ready
  );
  modport sink (
    input  valid, left, top, box_width, box_height, confidence, class_id,
    output ready
  );
endinterface

// ===== rtl/dbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_front
// Takes items, keeps the running argmax, writes thresholds and qualifies boxes.
// ----------------------------------------------------------------------------
module dbp_front import dbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dbp_in_if.sink            in_ch,
  input  logic [TCNT_W-1:0] thr_count,
  input  q_status_t         q_stat,
  output logic              push,
  output job_t              push_job
);

  logic             accept;
  func_t            func;
  logic [VAL_W-1:0] lead_score_r, lead_score_nxt;
  logic [CLS_W-1:0] lead_class_r, lead_class_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             st_v_r, st_v_nxt;
  logic             st_ok_r;
  job_t             st_job_r;
  logic [VAL_W-1:0] thr_rdata;
  logic             is_box, is_thr;

  assign in_ch.ready = q_stat.room2;
  assign accept      = in_ch.valid && in_ch.ready;
  assign func        = func_t'(in_ch.func);
  assign is_box      = accept && (func == FUNC_BOX);
  assign is_thr      = accept && (func == FUNC_THR);

  dbp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CLASSES)) u_thr_ram (
    .clk   (clk),
    .we    (is_thr),
    .waddr (in_ch.class_index),
    .wdata (in_ch.threshold_value),
    .re    (is_box),
    .raddr (lead_class_r),
    .rdata (thr_rdata)
  );

  always_comb begin
    lead_score_nxt = lead_score_r;
    lead_class_nxt = lead_class_r;
    cnt_nxt        = cnt_r;
    st_v_nxt       = 1'b0;
    if (accept) begin
      unique case (func)
        FUNC_SCORE: begin
          if (cnt_r < CNT_W'(MAX_CLASSES)) begin
            if ((cnt_r == '0) || (in_ch.score > lead_score_r)) begin
              lead_score_nxt = in_ch.score;
              lead_class_nxt = cnt_r[CLS_W-1:0];
            end
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        FUNC_BOX: begin
          st_v_nxt       = 1'b1;
          lead_score_nxt = '0;
          lead_class_nxt = '0;
          cnt_nxt        = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_score_r <= '0;
      lead_class_r <= '0;
      cnt_r        <= '0;
      st_v_r       <= 1'b0;
    end else begin
      lead_score_r <= lead_score_nxt;
      lead_class_r <= lead_class_nxt;
      cnt_r        <= cnt_nxt;
      st_v_r       <= st_v_nxt;
    end
  end

  // Box snapshot is registered in step with the threshold read
  always_ff @(posedge clk) begin
    if (is_box) begin
      st_job_r.center_x <= in_ch.center_x;
      st_job_r.center_y <= in_ch.center_y;
      st_job_r.size_x   <= in_ch.size_x;
      st_job_r.size_y   <= in_ch.size_y;
      st_job_r.score    <= lead_score_r;
      st_job_r.class_id <= lead_class_r;
      st_ok_r           <= (cnt_r != '0) && ({1'b0, lead_class_r} < thr_count);
    end
  end

  assign push     = st_v_r && st_ok_r && (st_job_r.score >= thr_rdata);
  assign push_job = st_job_r;

endmodule

// ===== rtl/dbp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_queue
// Short FIFO of qualified boxes between front and back.
// ----------------------------------------------------------------------------
module dbp_queue import dbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t stat
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

  assign head           = mem[rd_r];
  assign stat.room2     = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign stat.not_empty = cnt_r != '0;
  assign stat.full      = cnt_r == QCNT_W'(QDEPTH);

endmodule

// ===== rtl/dbp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_back
// Decodes queued boxes to clamped pixel corners and holds the result register.
// ----------------------------------------------------------------------------
module dbp_back import dbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NET_W-1:0] net_width,
  input  logic [NET_W-1:0] net_height,
  input  job_t             head,
  input  q_status_t        q_stat,
  output logic             pop,
  dbp_out_if.source        out_ch
);

  // Round a 2^-17 pixel value to Q12.4 and clamp to [0, lim]
  function automatic logic [VAL_W-1:0] to_px(input logic signed [32:0] v,
                                             input logic [VAL_W-1:0] lim);
    logic signed [32:0] t;
    logic [18:0]        r;
    t = v + 33'sd4096;
    r = t[31:13];
    if (t[32]) begin
      return '0;
    end else if (r > {3'b0, lim}) begin
      return lim;
    end else begin
      return r[VAL_W-1:0];
    end
  endfunction

  logic                     p_v_r, p_v_nxt;
  logic signed [32:0]       px1_r, px2_r, py1_r, py2_r;
  logic [VAL_W-1:0]         p_score_r;
  logic [CLS_W-1:0]         p_class_r;
  logic signed [18:0]       dx1, dx2, dy1, dy2;
  logic signed [NET_W:0]    nw_s, nh_s;
  logic [VAL_W-1:0]         limx, limy;
  logic [VAL_W-1:0]         x1, x2, y1, y2, bw, bh;
  logic                     emit, out_free;
  logic                     out_v_r, out_v_nxt;

  assign out_free = !out_v_r || out_ch.ready;
  assign pop      = q_stat.not_empty && (!p_v_r || out_free);
  assign p_v_nxt  = pop ? 1'b1 : (p_v_r && !out_free);

  assign nw_s = $signed({1'b0, net_width});
  assign nh_s = $signed({1'b0, net_height});
  assign dx1  = $signed({2'b0, head.center_x, 1'b0}) - $signed({3'b0, head.size_x});
  assign dx2  = $signed({2'b0, head.center_x, 1'b0}) + $signed({3'b0, head.size_x});
  assign dy1  = $signed({2'b0, head.center_y, 1'b0}) - $signed({3'b0, head.size_y});
  assign dy2  = $signed({2'b0, head.center_y, 1'b0}) + $signed({3'b0, head.size_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      p_v_r   <= p_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Product stage: the edge products for x1, x2, y1 and y2, exact in units of 2^-17 pixel
  always_ff @(posedge clk) begin
    if (pop) begin
      px1_r     <= dx1 * nw_s;
      px2_r     <= dx2 * nw_s;
      py1_r     <= dy1 * nh_s;
      py2_r     <= dy2 * nh_s;
      p_score_r <= head.score;
      p_class_r <= head.class_id;
    end
  end

  // Limit is net*16 saturated to 16 bits
  assign limx = net_width[NET_W-1]  ? '1 : {net_width[NET_W-2:0], 4'b0};
  assign limy = net_height[NET_W-1] ? '1 : {net_height[NET_W-2:0], 4'b0};

  assign x1   = to_px(px1_r, limx);
  assign x2   = to_px(px2_r, limx);
  assign y1   = to_px(py1_r, limy);
  assign y2   = to_px(py2_r, limy);
  assign bw   = x2 - x1;
  assign bh   = y2 - y1;
  assign emit = (bw >= VAL_W'(16)) && (bh >= VAL_W'(16));

  assign out_v_nxt = out_free ? (p_v_r && emit) : out_v_r;

  always_ff @(posedge clk) begin
    if (out_free && p_v_r && emit) begin
      out_ch.left       <= x1;
      out_ch.top        <= y1;
      out_ch.box_width  <= bw;
      out_ch.box_height <= bh;
      out_ch.confidence <= p_score_r;
      out_ch.class_id   <= p_class_r;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

// ===== rtl/detection_box_postprocess.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_postprocess
// Per-query argmax, per-class threshold and centre-size to corner box decode.
// ----------------------------------------------------------------------------
// Usage notes:
//  - in_ch carries one request per cycle: a class score (scores of one query
//    arrive in class order), a box that closes the query, a threshold write
//    or a no-op. in_ch.ready drops only when the box queue is nearly full.
//  - out_ch carries at most one detection per box request: top-left corner and size
//    in Q12.4 pixels, confidence in Q0.16 and the winning class.
//  - APB port holds net width, net height and the threshold count; write it
//    only while the block is idle. pready is tied high, reads are immediate.
//  - Throughput: one request per cycle, sustained while out_ch is not stalled.
//  - Path: a box request's detection passes, in order, the box snapshot and
//    threshold read at the acceptance edge, the queue write, the product
//    stage and the result register before it shows on out_ch.
//  - Reset (synchronous, rst_n low) clears the argmax, the queue and the
//    result valid flag and loads net size 640 x 640, threshold count 0. The
//    threshold table is not cleared; load it before use.
//  - A stalled out_ch holds its result; the 4-entry box queue keeps taking
//    requests until it has room for fewer than two more boxes.
// ----------------------------------------------------------------------------
module detection_box_postprocess import dbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  dbp_in_if.sink             in_ch,
  dbp_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [NET_W-1:0]  net_width_r,  net_width_nxt;
  logic [NET_W-1:0]  net_height_r, net_height_nxt;
  logic [TCNT_W-1:0] thr_count_r,  thr_count_nxt;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t q_stat;

  // --- configuration registers ---------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    net_width_nxt  = net_width_r;
    net_height_nxt = net_height_r;
    thr_count_nxt  = thr_count_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_NET_WIDTH:  net_width_nxt  = pwdata[NET_W-1:0];
        REG_NET_HEIGHT: net_height_nxt = pwdata[NET_W-1:0];
        REG_THR_COUNT:  thr_count_nxt  = pwdata[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NET_WIDTH:  prdata = PDATA_W'(net_width_r);
      REG_NET_HEIGHT: prdata = PDATA_W'(net_height_r);
      REG_THR_COUNT:  prdata = PDATA_W'(thr_count_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_width_r  <= NET_W'(640);
      net_height_r <= NET_W'(640);
      thr_count_r  <= '0;
    end else begin
      net_width_r  <= net_width_nxt;
      net_height_r <= net_height_nxt;
      thr_count_r  <= thr_count_nxt;
    end
  end

  // --- front: argmax, threshold table, box qualification --------------------
  dbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .thr_count (thr_count_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // --- queue decoupling front from decode -----------------------------------
  dbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // --- back: box decode and result register ---------------------------------
  dbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .net_width  (net_width_r),
    .net_height (net_height_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // --- checks ---------------------------------------------------------------
  // A box only enters the queue in the cycle after a box request was taken
  a_push_after_box: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(in_ch.valid && in_ch.ready && (in_ch.func == FUNC_BOX)))
    else $error("queue push without a preceding box request");

  // Flow control must keep a slot for the box in flight
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full && !pop))
    else $error("box queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("box queue underflow");

  // Input stalls only because boxes are waiting downstream
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.not_empty)
    else $error("input stalled with an empty queue");

endmodule

// ===== tb/detection_box_postprocess_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_postprocess_checker
// Watches the request channels and the APB port, predicts each detection and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module detection_box_postprocess_checker import dbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  dbp_in_if                  in_ch,
  dbp_out_if                 out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatches,
  output int                 pending,
  output int                 dets_seen
);

  typedef struct packed {
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] top;
    logic [VAL_W-1:0] box_width;
    logic [VAL_W-1:0] box_height;
    logic [VAL_W-1:0] confidence;
    logic [CLS_W-1:0] class_id;
  } det_t;

  det_t              expected_dets[$];
  logic [NET_W-1:0]  net_w;
  logic [NET_W-1:0]  net_h;
  logic [TCNT_W-1:0] thr_cnt;
  logic [VAL_W-1:0]  lead_score;
  logic [CLS_W-1:0]  lead_class;
  logic [CNT_W-1:0]  scores_seen;
  logic [VAL_W-1:0]  thr_tab [MAX_CLASSES];
  int                errs = 0;
  int                seen = 0;

  // Edge in 2^-17 pixel, rounded to Q12.4 (floor of +half) and clamped
  function automatic longint corner_px(input logic [VAL_W-1:0] c,
                                       input logic [VAL_W-1:0] s,
                                       input bit               far,
                                       input logic [NET_W-1:0] n);
    longint lim;
    longint t;
    longint r;
    lim = longint'(n) * 16;
    if (lim > 65535) lim = 65535;
    t = (far ? 2 * longint'(c) + longint'(s) : 2 * longint'(c) - longint'(s))
        * longint'(n) + 4096;
    if (t < 0) return 0;
    r = t >>> 13;
    return (r > lim) ? lim : r;
  endfunction

  task automatic close_query();
    longint x1;
    longint x2;
    longint y1;
    longint y2;
    bit     keep;
    det_t   d;
    keep = (scores_seen != 0) && (lead_class < thr_cnt) &&
           (lead_score >= thr_tab[lead_class]);
    x1 = corner_px(in_ch.center_x, in_ch.size_x, 1'b0, net_w);
    x2 = corner_px(in_ch.center_x, in_ch.size_x, 1'b1, net_w);
    y1 = corner_px(in_ch.center_y, in_ch.size_y, 1'b0, net_h);
    y2 = corner_px(in_ch.center_y, in_ch.size_y, 1'b1, net_h);
    if ((x2 - x1) < 16 || (y2 - y1) < 16) keep = 1'b0;
    if (keep) begin
      d.left       = x1[VAL_W-1:0];
      d.top        = y1[VAL_W-1:0];
      d.box_width  = 16'(x2 - x1);
      d.box_height = 16'(y2 - y1);
      d.confidence = lead_score;
      d.class_id   = lead_class;
      expected_dets.insert(expected_dets.size(), d);
    end
    lead_score  = '0;
    lead_class  = '0;
    scores_seen = '0;
  endtask

  always @(posedge clk) begin : watch
    det_t got;
    det_t want;
    if (!rst_n) begin
      net_w       = 13'd640;
      net_h       = 13'd640;
      thr_cnt     = '0;
      lead_score  = '0;
      lead_class  = '0;
      scores_seen = '0;
      expected_dets.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_NET_WIDTH:  net_w   = pwdata[NET_W-1:0];
          REG_NET_HEIGHT: net_h   = pwdata[NET_W-1:0];
          REG_THR_COUNT:  thr_cnt = pwdata[TCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (func_t'(in_ch.func))
          FUNC_SCORE: begin
            if (scores_seen < MAX_CLASSES) begin
              if (scores_seen == 0 || in_ch.score > lead_score) begin
                lead_score = in_ch.score;
                lead_class = scores_seen[CLS_W-1:0];
              end
              scores_seen++;
            end
          end
          FUNC_THR: thr_tab[in_ch.class_index] = in_ch.threshold_value;
          FUNC_BOX: close_query();
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{left: out_ch.left, top: out_ch.top, box_width: out_ch.box_width,
                box_height: out_ch.box_height, confidence: out_ch.confidence,
                class_id: out_ch.class_id};
        seen++;
        if (expected_dets.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected detection: l=%h t=%h w=%h h=%h conf=%h cls=%0d",
                     got.left, got.top, got.box_width, got.box_height,
                     got.confidence, got.class_id);
        end else begin
          want = expected_dets.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("detection mismatch: exp l=%h t=%h w=%h h=%h conf=%h cls=%0d",
                       want.left, want.top, want.box_width, want.box_height,
                       want.confidence, want.class_id);
              $display("                    got l=%h t=%h w=%h h=%h conf=%h cls=%0d",
                       got.left, got.top, got.box_width, got.box_height,
                       got.confidence, got.class_id);
            end
          end
        end
      end
    end
    mismatches <= errs;
    pending    <= expected_dets.size();
    dets_seen  <= seen;
  end

endmodule

// ===== tb/detection_box_postprocess_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_postprocess_tb
// Drives score, box, threshold and no-op requests plus APB register settings
// into the post-processing block; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module detection_box_postprocess_tb;
  import dbp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 12;   // settle margin beyond the box decode path
  localparam int PHASES       = 8;
  localparam int PHASE_REQS   = 90;

  typedef struct packed {
    func_t            func;
    logic [VAL_W-1:0] score;
    logic [CLS_W-1:0] class_index;
    logic [VAL_W-1:0] threshold_value;
    logic [VAL_W-1:0] center_x;
    logic [VAL_W-1:0] center_y;
    logic [VAL_W-1:0] size_x;
    logic [VAL_W-1:0] size_y;
  } req_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dbp_in_if  in_ch ();
  dbp_out_if out_ch ();

  int mismatches;
  int pending;
  int dets_seen;
  int idle_pct      = 0;   // chance in a hundred the sender holds off
  int stall_pct     = 0;   // chance in a hundred the receiver holds off
  int reqs_sent     = 0;
  int settings_used = 0;
  int pauses        = 0;

  // Register settings per random phase: width, height, threshold count.
  // Covers unit and maximum net sizes, zero net size, 13-bit overrange,
  // no thresholded classes and every class thresholded.
  int unsigned phase_w [PHASES] = '{640, 1, 4096, 0, 8191, 4096, 320, 0};
  int unsigned phase_h [PHASES] = '{480, 1, 4096, 640, 100, 1, 320, 0};
  int unsigned phase_c [PHASES] = '{128, 128, 128, 64, 255, 0, 10, 0};

  always #2 clk = ~clk;

  detection_box_postprocess u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  detection_box_postprocess_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending),
    .dets_seen  (dets_seen)
  );

  // Result side back-pressure, re-rolled every cycle
  initial begin : result_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Request builders; fields the function ignores carry random junk
  // --------------------------------------------------------------------------
  function automatic req_t junk_req();
    req_t r;
    r.func            = FUNC_NOP;
    r.score           = 16'($urandom);
    r.class_index     = 7'($urandom);
    r.threshold_value = 16'($urandom);
    r.center_x        = 16'($urandom);
    r.center_y        = 16'($urandom);
    r.size_x          = 16'($urandom);
    r.size_y          = 16'($urandom);
    return r;
  endfunction

  function automatic req_t mk_score(input logic [VAL_W-1:0] s);
    req_t r;
    r       = junk_req();
    r.func  = FUNC_SCORE;
    r.score = s;
    return r;
  endfunction

  function automatic req_t mk_thr(input logic [CLS_W-1:0] ci, input logic [VAL_W-1:0] v);
    req_t r;
    r                 = junk_req();
    r.func            = FUNC_THR;
    r.class_index     = ci;
    r.threshold_value = v;
    return r;
  endfunction

  function automatic req_t mk_box(input logic [VAL_W-1:0] cx, input logic [VAL_W-1:0] cy,
                                  input logic [VAL_W-1:0] sx, input logic [VAL_W-1:0] sy);
    req_t r;
    r          = junk_req();
    r.func     = FUNC_BOX;
    r.center_x = cx;
    r.center_y = cy;
    r.size_x   = sx;
    r.size_y   = sy;
    return r;
  endfunction

  // Mostly modest box sizes so that clamping does not swamp the decode
  function automatic logic [VAL_W-1:0] rand_size();
    return ($urandom_range(1)) ? 16'($urandom_range(16'h3000)) : 16'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] rand_thr();
    return ($urandom_range(9) < 6) ? 16'($urandom_range(16'h3fff)) : 16'($urandom);
  endfunction

  function automatic req_t rand_box();
    return mk_box(16'($urandom), 16'($urandom), rand_size(), rand_size());
  endfunction

  // --------------------------------------------------------------------------
  // Channel and bus tasks
  // --------------------------------------------------------------------------
  task automatic send(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= r.func;
    in_ch.score           <= r.score;
    in_ch.class_index     <= r.class_index;
    in_ch.threshold_value <= r.threshold_value;
    in_ch.center_x        <= r.center_x;
    in_ch.center_y        <= r.center_y;
    in_ch.size_x          <= r.size_x;
    in_ch.size_y          <= r.size_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reqs_sent++;
  endtask

  // Stop sending and let every predicted detection come out. The first edge
  // lets the checker count a box accepted at the current edge.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phases, then idle with psel low before the next transfer
  task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change with the block idle
  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned c);
    drain();
    reg_write(REG_NET_WIDTH, w);
    reg_write(REG_NET_HEIGHT, h);
    reg_write(REG_THR_COUNT, c);
    settings_used++;
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 87; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 87; end
      default: begin idle_pct = 7;  stall_pct = 7;  end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly complete queries (scores then a box), with stray
  // boxes, no-ops and threshold rewrites as noise. Now and then the sender
  // holds off until the block has emptied.
  // --------------------------------------------------------------------------
  task automatic random_phase(input int budget);
    int               stop;
    int               n;
    int               k;
    logic [VAL_W-1:0] s;
    stop = reqs_sent + budget;
    while (reqs_sent < stop) begin
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(99);
        if (k < 70)      n = $urandom_range(6, 1);
        else if (k < 90) n = $urandom_range(40, 7);
        else if (k < 98) n = $urandom_range(MAX_CLASSES, 41);
        else             n = $urandom_range(MAX_CLASSES + 12, MAX_CLASSES + 1);
        s = 16'($urandom);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(4) != 0) s = 16'($urandom);   // else repeat: tie
          send(mk_score(s));
          if ($urandom_range(29) == 0)
            send(mk_thr(7'($urandom), rand_thr()));
          else if ($urandom_range(49) == 0)
            send(junk_req());
        end
        send(rand_box());
        if (pauses == 0 || $urandom_range(29) == 0) begin
          pauses++;
          drain();
        end
      end else begin
        case ($urandom_range(2))
          0:       send(rand_box());
          1:       send(junk_req());
          default: send(mk_thr(7'($urandom), rand_thr()));
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= FUNC_NOP;
    in_ch.score           <= '0;
    in_ch.class_index     <= '0;
    in_ch.threshold_value <= '0;
    in_ch.center_x        <= '0;
    in_ch.center_y        <= '0;
    in_ch.size_x          <= '0;
    in_ch.size_y          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(0);
    configure(640, 480, MAX_CLASSES);

    // The table has no reset value: fill every entry before any box reads it
    for (int i = 0; i < MAX_CLASSES; i++)
      send(mk_thr(7'(i), 16'($urandom_range(16'h1000))));

    // Directed part
    send(rand_box());                          // box with no scores: nothing out
    repeat (3) send(mk_score(16'h8000));       // three-way tie keeps class 0
    send(mk_box(16'h0000, 16'h0000, 16'hffff, 16'hffff));  // low edges clamp to 0
    send(mk_score(16'h0000));                  // tie at the top keeps class 1
    repeat (2) send(mk_score(16'hffff));
    send(mk_box(16'hffff, 16'hffff, 16'hffff, 16'hffff));  // high edges clamp
    send(junk_req());                          // no-op
    send(mk_thr(7'd5, 16'hffff));
    repeat (5) send(mk_score(16'h0000));       // class 5 wins just below threshold
    send(mk_score(16'hfffe));
    send(mk_box(16'h8000, 16'h8000, 16'h2000, 16'h2000));
    repeat (5) send(mk_score(16'h0000));       // score equal to threshold passes
    send(mk_score(16'hffff));
    send(mk_box(16'h8000, 16'h8000, 16'h2000, 16'h2000));
    send(mk_score(16'hffff));                  // zero-size box is dropped
    send(mk_box(16'h8000, 16'h8000, 16'h0000, 16'h0000));

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1)
        configure($urandom_range(4096, 1), $urandom_range(4096, 1),
                  $urandom_range(MAX_CLASSES, 1));
      else
        configure(phase_w[p], phase_h[p], phase_c[p]);
      set_pace(p % 4);
      random_phase(PHASE_REQS);
    end

    drain();
    $display("Run covered %0d requests and %0d detections over %0d register settings,",
             reqs_sent, dets_seen, settings_used);
    $display("with idle sender, stalled receiver, mixed and free-running phases.");
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("Timeout after %0d cycles, %0d detections still awaited", cyc, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
